### design/ceec_pkg.sv
// Shared types and constants for the I2C EEPROM card emulator.
`timescale 1ns / 1ps

package ceec_pkg;

  // Pointer and field widths
  localparam int PTR_W      = 13;
  localparam int BYTE_W     = 8;
  localparam int MS_W       = 16;
  localparam int CMD_W      = 3;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Default memory size, and the reciprocal shift used for the index reduction
  localparam int MEM_BYTES_DEF = 8192;
  localparam int RECIP_SHIFT   = 30;

  localparam logic [MS_W-1:0] MS_MAX = '1;

  // Register reset values
  localparam logic [PTR_W-1:0] FINISH_RST  = 13'h1FFF;
  localparam logic [MS_W-1:0]  TIMEOUT_RST = 16'd100;
  localparam logic [MS_W-1:0]  END_RST     = 16'd100;
  localparam logic [MS_W-1:0]  UNPLUG_RST  = 16'd100;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FINISH_ADDRESS = 8'd0,
    REG_TRANSFER_TO    = 8'd1,
    REG_END_DELAY      = 8'd2,
    REG_UNPLUG_DELAY   = 8'd3
  } cfg_reg_t;

  // Input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 3'd0,
    CMD_READ    = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_TICK    = 3'd3,
    CMD_TRIGGER = 3'd4
  } cmd_t;

  // Bus byte phase
  typedef enum logic [1:0] {
    BP_ADDR_HI = 2'd0,
    BP_ADDR_LO = 2'd1,
    BP_DATA    = 2'd2
  } bus_phase_t;

  // Reading session phase
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_TRANSMIT = 2'd1,
    PH_END_WAIT = 2'd2,
    PH_UNPLUG   = 2'd3
  } phase_t;

  // Item sequencer
  typedef enum logic [1:0] {
    SQ_WARMUP = 2'd0,
    SQ_SETTLE = 2'd1,
    SQ_READY  = 2'd2,
    SQ_ISSUE  = 2'd3
  } seq_state_t;

  // Memory request from the control logic
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [BYTE_W-1:0] wr_data;
  } mem_req_t;

  // Result status held by the control logic between items
  typedef struct packed {
    logic             rd_sel;
    logic             write_strobe;
    logic             card_present;
    logic             session_active;
    logic             finished_pulse;
    phase_t           session_phase;
    logic [PTR_W-1:0] pointer_now;
  } res_stat_t;

endpackage

### design/ceec_mem.sv
// Card memory: single port, synchronous, registered read.
`timescale 1ns / 1ps

module ceec_mem #(
  parameter int MEM_BYTES = ceec_pkg::MEM_BYTES_DEF,
  parameter int AW        = $clog2(MEM_BYTES)
) (
  input  logic                        clk,
  input  logic [AW-1:0]               addr,
  input  ceec_pkg::mem_req_t          req,
  output logic [ceec_pkg::BYTE_W-1:0] rd_data
);

  logic [ceec_pkg::BYTE_W-1:0] mem [MEM_BYTES];

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[addr] <= req.wr_data;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

### design/ceec_index.sv
// Pointer modulo memory size, as a two-stage reciprocal reduction.
`timescale 1ns / 1ps

module ceec_index #(
  parameter int MEM_BYTES = ceec_pkg::MEM_BYTES_DEF,
  parameter int AW        = $clog2(MEM_BYTES)
) (
  input  logic                       clk,
  input  logic [ceec_pkg::PTR_W-1:0] pointer,
  output logic [AW-1:0]              index
);

  localparam int PW_   = ceec_pkg::PTR_W;
  localparam int SH    = ceec_pkg::RECIP_SHIFT;
  localparam longint RECIP = ((64'd1 << SH) + MEM_BYTES - 1) / MEM_BYTES;
  localparam int RW    = $clog2(RECIP + 1);
  localparam int PRW   = (PW_ + RW > SH + 1) ? PW_ + RW : SH + 1;
  localparam int QW    = PRW - SH;
  localparam int QMW   = QW + 17;

  logic [PRW-1:0] prod;
  logic [PW_-1:0] ptr_d;
  logic [QW-1:0]  quot;
  logic [QMW-1:0] qm;
  logic [PW_-1:0] rem;

  // Stage 1: pointer times reciprocal
  always_ff @(posedge clk) begin
    prod  <= PRW'(pointer) * PRW'(RECIP);
    ptr_d <= pointer;
  end

  // Stage 2: subtract quotient times size
  assign quot = prod[PRW-1:SH];
  assign qm   = QMW'(quot) * QMW'(MEM_BYTES);
  assign rem  = ptr_d - qm[PW_-1:0];

  always_ff @(posedge clk) begin
    index <= AW'(rem);
  end

endmodule

### design/ceec_ctrl.sv
// Bus byte handling, pointer, session phases and configuration registers.
`timescale 1ns / 1ps

module ceec_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  ceec_pkg::cmd_t                  cmd,
  input  logic [ceec_pkg::BYTE_W-1:0]     write_data,
  input  logic                            cfg_we,
  input  logic [ceec_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ceec_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic [ceec_pkg::PTR_W-1:0]      pointer,
  output ceec_pkg::mem_req_t              mem_req,
  output ceec_pkg::res_stat_t             stat
);

  logic [ceec_pkg::PTR_W-1:0] finish_address;
  logic [ceec_pkg::MS_W-1:0]  transfer_timeout_ms;
  logic [ceec_pkg::MS_W-1:0]  end_delay_ms;
  logic [ceec_pkg::MS_W-1:0]  unplug_delay_ms;

  logic [ceec_pkg::PTR_W-1:0] pointer_next;
  ceec_pkg::bus_phase_t       bus_phase, bus_phase_next;
  ceec_pkg::phase_t           phase, phase_next;
  logic [ceec_pkg::MS_W-1:0]  elapsed_ms, elapsed_ms_next;
  logic [ceec_pkg::MS_W-1:0]  elapsed_inc;
  logic                       active_flag, active_flag_next;
  logic                       plugged_flag, plugged_flag_next;
  logic                       strobe_next, fin_next, rd_sel_next;
  logic                       write_strobe, finished_pulse, rd_sel;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      finish_address      <= ceec_pkg::FINISH_RST;
      transfer_timeout_ms <= ceec_pkg::TIMEOUT_RST;
      end_delay_ms        <= ceec_pkg::END_RST;
      unplug_delay_ms     <= ceec_pkg::UNPLUG_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        ceec_pkg::REG_FINISH_ADDRESS: finish_address <= cfg_wdata[ceec_pkg::PTR_W-1:0];
        ceec_pkg::REG_TRANSFER_TO:    transfer_timeout_ms <= cfg_wdata;
        ceec_pkg::REG_END_DELAY:      end_delay_ms <= cfg_wdata;
        ceec_pkg::REG_UNPLUG_DELAY:   unplug_delay_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign elapsed_inc = (elapsed_ms != ceec_pkg::MS_MAX) ? elapsed_ms + 1'b1 : elapsed_ms;

  // Next state for one item
  always_comb begin
    pointer_next      = pointer;
    bus_phase_next    = bus_phase;
    phase_next        = phase;
    elapsed_ms_next   = elapsed_ms;
    active_flag_next  = active_flag;
    plugged_flag_next = plugged_flag;
    strobe_next       = 1'b0;
    fin_next          = 1'b0;
    rd_sel_next       = 1'b0;
    case (cmd)
      ceec_pkg::CMD_WRITE: begin
        case (bus_phase)
          ceec_pkg::BP_ADDR_HI: begin
            pointer_next   = {write_data[ceec_pkg::PTR_W-9:0], 8'd0};
            bus_phase_next = ceec_pkg::BP_ADDR_LO;
          end
          ceec_pkg::BP_ADDR_LO: begin
            pointer_next   = pointer + ceec_pkg::PTR_W'(write_data);
            bus_phase_next = ceec_pkg::BP_DATA;
          end
          default: begin
            pointer_next = pointer + 1'b1;
            strobe_next  = 1'b1;
          end
        endcase
        elapsed_ms_next = '0;
      end
      ceec_pkg::CMD_READ: begin
        rd_sel_next  = 1'b1;
        pointer_next = pointer + 1'b1;
        if (phase == ceec_pkg::PH_IDLE && active_flag) begin
          phase_next = ceec_pkg::PH_TRANSMIT;
        end
        elapsed_ms_next = '0;
      end
      ceec_pkg::CMD_STOP: begin
        bus_phase_next = ceec_pkg::BP_ADDR_HI;
        if (finish_address <= pointer && active_flag) begin
          phase_next = ceec_pkg::PH_END_WAIT;
        end
        elapsed_ms_next = '0;
      end
      ceec_pkg::CMD_TICK: begin
        elapsed_ms_next = elapsed_inc;
        case (phase)
          ceec_pkg::PH_TRANSMIT: begin
            if (elapsed_inc > transfer_timeout_ms) begin
              phase_next      = ceec_pkg::PH_END_WAIT;
              elapsed_ms_next = '0;
            end
          end
          ceec_pkg::PH_END_WAIT: begin
            if (elapsed_inc > end_delay_ms) begin
              phase_next        = ceec_pkg::PH_UNPLUG;
              plugged_flag_next = 1'b0;
              elapsed_ms_next   = '0;
            end
          end
          ceec_pkg::PH_UNPLUG: begin
            // counter is left running on expiry
            if (elapsed_inc > unplug_delay_ms) begin
              phase_next       = ceec_pkg::PH_IDLE;
              active_flag_next = 1'b0;
              fin_next         = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ceec_pkg::CMD_TRIGGER: begin
        active_flag_next  = 1'b1;
        plugged_flag_next = 1'b1;
      end
      default: ;
    endcase
  end

  // State registers, updated on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      pointer        <= '0;
      bus_phase      <= ceec_pkg::BP_ADDR_HI;
      phase          <= ceec_pkg::PH_IDLE;
      elapsed_ms     <= '0;
      active_flag    <= 1'b0;
      plugged_flag   <= 1'b0;
      write_strobe   <= 1'b0;
      finished_pulse <= 1'b0;
      rd_sel         <= 1'b0;
    end else if (accept) begin
      pointer        <= pointer_next;
      bus_phase      <= bus_phase_next;
      phase          <= phase_next;
      elapsed_ms     <= elapsed_ms_next;
      active_flag    <= active_flag_next;
      plugged_flag   <= plugged_flag_next;
      write_strobe   <= strobe_next;
      finished_pulse <= fin_next;
      rd_sel         <= rd_sel_next;
    end
  end

  // Memory access uses the index of the pointer before this item
  assign mem_req.wr_en   = accept && strobe_next;
  assign mem_req.rd_en   = accept && rd_sel_next;
  assign mem_req.wr_data = write_data;

  assign stat.rd_sel         = rd_sel;
  assign stat.write_strobe   = write_strobe;
  assign stat.card_present   = plugged_flag;
  assign stat.session_active = active_flag;
  assign stat.finished_pulse = finished_pulse;
  assign stat.session_phase  = phase;
  assign stat.pointer_now    = pointer;

endmodule

### design/i2c_eeprom_card_emulator_unit.sv
// Top level of the I2C EEPROM card emulator.
//
//  channel   direction  handshake                beat contents
//  s_axis    in         s_tvalid / s_tready      tuser cmd, tdata write_data
//  m_axis    out        m_tvalid / m_tready      tdata result fields
//  cfg       in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Each item is accepted in the ready state, which also issues the memory
// access; the issue and settle states then let the pointer-to-index
// reduction settle before the next item is taken. m_tvalid is registered
// and raised from the issue state. After reset the block passes through
// warm-up and settle for the index pipeline; memory is not cleared. A stalled
// result holds the input off until it is taken; cfg_ready is always high.
`timescale 1ns / 1ps

module i2c_eeprom_card_emulator_unit #(
  parameter int MEM_BYTES = ceec_pkg::MEM_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] write_data
  input  logic [7:0]                      s_tuser,   // [2:0] cmd, rest zero
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [7:0] read_data, [8] write_strobe, [9] card_present, [10] session_active,
  // [11] finished_pulse, [13:12] session_phase, [26:14] pointer_now, rest zero
  output logic [31:0]                     m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ceec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ceec_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MEM_BYTES);

  ceec_pkg::seq_state_t        state, state_next;
  logic                        accept;
  logic                        m_valid_next;
  logic [ceec_pkg::PTR_W-1:0]  pointer;
  logic [AW-1:0]               index;
  logic [ceec_pkg::BYTE_W-1:0] rd_data;
  ceec_pkg::mem_req_t          mem_req;
  ceec_pkg::res_stat_t         stat;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ceec_pkg::SQ_WARMUP;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_valid_next;
    end
  end

  // Sequencer next state and handshake
  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    m_valid_next = m_tvalid && !m_tready;
    case (state)
      ceec_pkg::SQ_WARMUP: state_next = ceec_pkg::SQ_SETTLE;
      ceec_pkg::SQ_SETTLE: state_next = ceec_pkg::SQ_READY;
      ceec_pkg::SQ_READY: begin
        s_tready = !m_tvalid || m_tready;
        if (s_tvalid && s_tready) begin
          state_next = ceec_pkg::SQ_ISSUE;
        end
      end
      ceec_pkg::SQ_ISSUE: begin
        m_valid_next = 1'b1;
        state_next   = ceec_pkg::SQ_SETTLE;
      end
      default: state_next = ceec_pkg::SQ_WARMUP;
    endcase
  end

  ceec_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cmd        (ceec_pkg::cmd_t'(s_tuser[ceec_pkg::CMD_W-1:0])),
    .write_data (s_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .pointer    (pointer),
    .mem_req    (mem_req),
    .stat       (stat)
  );

  ceec_index #(
    .MEM_BYTES (MEM_BYTES),
    .AW        (AW)
  ) u_index (
    .clk     (clk),
    .pointer (pointer),
    .index   (index)
  );

  ceec_mem #(
    .MEM_BYTES (MEM_BYTES),
    .AW        (AW)
  ) u_mem (
    .clk     (clk),
    .addr    (index),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Result beat
  assign m_tdata = {5'd0,
                    stat.pointer_now,
                    stat.session_phase,
                    stat.finished_pulse,
                    stat.session_active,
                    stat.card_present,
                    stat.write_strobe,
                    stat.rd_sel ? rd_data : 8'd0};

endmodule

### tb/sv/tb_i2c_eeprom_card_emulator_unit.sv
// Self-checking testbench for the I2C EEPROM card emulator: bus traffic, session timing, registers.
`timescale 1ns / 1ps

module tb_i2c_eeprom_card_emulator_unit;
  import ceec_pkg::*;

  localparam int MEM_SIZE     = MEM_BYTES_DEF;
  localparam int CMD_TOP      = (1 << CMD_W) - 1;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 200;
  localparam int STALL_CYCLES = 400;
  localparam int SETTLE       = 12;
  localparam int WATCHDOG     = 4000;
  localparam int SAT_TICKS    = 60;

  // indexes past the last register, which the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_SPARE   = REG_UNPLUG_DELAY + 1;
  localparam logic [CFG_IDX_W-1:0] REG_IDX_TOP = '1;

  // result beat layout, highest bits first
  typedef struct packed {
    logic [4:0]       spare;
    logic [PTR_W-1:0] ptr_now;
    phase_t           phase;
    logic             fin;
    logic             active;
    logic             present;
    logic             strobe;
    logic [7:0]       rd;
  } card_reply_t;

  // Card state tracker: predicts each reply and matches the replies seen
  class card_tracker;
    bit [7:0]          mem [MEM_SIZE];
    bit                written [MEM_SIZE];
    int                filled [$];
    logic [PTR_W-1:0]  ptr;
    bus_phase_t        bus_ph;
    phase_t            sess;
    logic [MS_W-1:0]   elapsed;
    logic              active, plugged;
    logic [PTR_W-1:0]  finish;
    logic [MS_W-1:0]   tmo, end_dly, unplug_dly;
    card_reply_t       replies_due [$];
    int items, replies, errors, strobes, reads, fins, cfg_writes;

    function void clear();
      ptr = '0; bus_ph = BP_ADDR_HI; sess = PH_IDLE; elapsed = '0;
      active = 1'b0; plugged = 1'b0;
      finish = FINISH_RST; tmo = TIMEOUT_RST; end_dly = END_RST; unplug_dly = UNPLUG_RST;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      cfg_writes++;
      case (idx)
        REG_FINISH_ADDRESS: finish     = data[PTR_W-1:0];
        REG_TRANSFER_TO:    tmo        = data;
        REG_END_DELAY:      end_dly    = data;
        REG_UNPLUG_DELAY:   unplug_dly = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    // one accepted input beat: advance the card state and queue the reply
    function void take_item(logic [2:0] cmd, logic [7:0] data);
      card_reply_t r;
      int idx;
      r = '0;
      idx = int'(ptr) % MEM_SIZE;
      items++;
      case (cmd)
        CMD_WRITE: begin
          case (bus_ph)
            BP_ADDR_HI: begin
              ptr = {data[4:0], 8'h00};
              bus_ph = BP_ADDR_LO;
            end
            BP_ADDR_LO: begin
              ptr = ptr + PTR_W'(data);
              bus_ph = BP_DATA;
            end
            default: begin
              mem[idx] = data;
              if (!written[idx]) filled.push_back(idx);
              written[idx] = 1'b1;
              ptr = ptr + 1'b1;
              r.strobe = 1'b1;
              strobes++;
            end
          endcase
          elapsed = '0;
        end
        CMD_READ: begin
          r.rd = mem[idx];
          ptr = ptr + 1'b1;
          if (sess == PH_IDLE && active) sess = PH_TRANSMIT;
          elapsed = '0;
          reads++;
        end
        CMD_STOP: begin
          bus_ph = BP_ADDR_HI;
          if (finish <= ptr && active) sess = PH_END_WAIT;
          elapsed = '0;
        end
        CMD_TICK: begin
          if (elapsed != MS_MAX) elapsed++;
          case (sess)
            PH_TRANSMIT: if (elapsed > tmo) begin
              sess = PH_END_WAIT;
              elapsed = '0;
            end
            PH_END_WAIT: if (elapsed > end_dly) begin
              sess = PH_UNPLUG;
              plugged = 1'b0;
              elapsed = '0;
            end
            PH_UNPLUG: if (elapsed > unplug_dly) begin
              sess = PH_IDLE;
              active = 1'b0;
              r.fin = 1'b1;
              fins++;
            end
            default: ;
          endcase
        end
        CMD_TRIGGER: begin
          active = 1'b1;
          plugged = 1'b1;
        end
        default: ;
      endcase
      r.present = plugged;
      r.active  = active;
      r.phase   = sess;
      r.ptr_now = ptr;
      replies_due.push_back(r);
    endfunction

    function void flag(string what, logic [15:0] exp, logic [15:0] act);
      errors++;
      if (errors <= 10)
        $display("  result %0d, %s: expected %0h, got %0h", replies, what, exp, act);
    endfunction

    function void check_field(string what, logic [15:0] exp, logic [15:0] act);
      if (exp !== act) flag(what, exp, act);
    endfunction

    // one accepted result beat against the oldest prediction
    function void match_reply(logic [31:0] raw);
      card_reply_t got, due;
      got = card_reply_t'(raw);
      replies++;
      if (replies_due.size() == 0) begin
        flag("result with nothing due", 16'h0, raw[15:0]);
        return;
      end
      due = replies_due.pop_front();
      check_field("read_data", due.rd, got.rd);
      check_field("write_strobe", due.strobe, got.strobe);
      check_field("card_present", due.present, got.present);
      check_field("session_active", due.active, got.active);
      check_field("finished_pulse", due.fin, got.fin);
      check_field("session_phase", due.phase, got.phase);
      check_field("pointer_now", due.ptr_now, got.ptr_now);
      check_field("padding", due.spare, got.spare);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid, s_tready;
  logic [7:0]            s_tdata, s_tuser;
  logic                  m_tvalid, m_tready;
  logic [31:0]           m_tdata;
  logic                  cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  card_tracker tracker;
  bit tx_gaps, rx_gaps, rush;
  int stall_req, stalls, tick_span, quiet;

  i2c_eeprom_card_emulator_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Watchdog: too long without any beat on any channel
  always @(posedge clk) begin
    if ((s_tvalid & s_tready) === 1'b1 || (m_tvalid & m_tready) === 1'b1 ||
        (cfg_valid & cfg_ready) === 1'b1)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               quiet, tracker.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: random ready gaps, one long hold-off per request
  initial begin : reply_sink
    int gap;
    m_tready = 1'b0;
    rx_gaps = 1'b1;
    forever begin
      gap = 0;
      if (stall_req > stalls) begin
        gap = STALL_CYCLES;
        stalls++;
      end else if (rx_gaps && !rush) begin
        gap = $urandom_range(0, 10);
      end
      if (!rush && $urandom_range(0, 39) == 0) rx_gaps = !rx_gaps;
      if (gap > 0) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1 || rst);
      tracker.match_reply(m_tdata);
    end
  end

  // one input beat; a read of never-written memory is turned into a stop
  task automatic send_beat(input logic [2:0] cmd, input logic [7:0] data);
    int gap;
    logic [2:0] c;
    c = cmd;
    gap = (tx_gaps && !rush) ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    if (c == CMD_READ && !tracker.written[int'(tracker.ptr) % MEM_SIZE]) c = CMD_STOP;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= {5'b0, c};
    s_tdata  <= data;
    do @(posedge clk); while (s_tready !== 1'b1);
    tracker.take_item(c, data);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tracker.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop offering, let every due result arrive, then let the block settle
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [PTR_W-1:0] pick_addr();
    case ($urandom_range(0, 3))
      0, 1:    return PTR_W'($urandom_range(0, 127));
      2:       return PTR_W'(13'h1FFF - $urandom_range(0, 15));
      default: return PTR_W'($urandom);
    endcase
  endfunction

  // address phase; the top three bits of the high byte are random
  task automatic set_pointer(input logic [PTR_W-1:0] a);
    if (tracker.bus_ph != BP_ADDR_HI) send_beat(CMD_STOP, 8'($urandom));
    send_beat(CMD_WRITE, {3'($urandom), a[12:8]});
    send_beat(CMD_WRITE, a[7:0]);
  endtask

  task automatic write_burst();
    int n;
    n = $urandom_range(1, 8);
    set_pointer(pick_addr());
    repeat (n) send_beat(CMD_WRITE, 8'($urandom));
    send_beat(CMD_STOP, 8'($urandom));
  endtask

  task automatic read_burst();
    int n;
    if (tracker.filled.size() == 0) begin
      write_burst();
      return;
    end
    n = $urandom_range(1, 8);
    set_pointer(PTR_W'(tracker.filled[$urandom_range(0, tracker.filled.size() - 1)]));
    send_beat(CMD_STOP, 8'($urandom));
    repeat (n) send_beat(CMD_READ, 8'($urandom));
    send_beat(CMD_STOP, 8'($urandom));
  endtask

  task automatic tick_burst();
    int n;
    n = ($urandom_range(0, 3) == 0) ? tick_span : $urandom_range(1, 8);
    repeat (n) send_beat(CMD_TICK, 8'($urandom));
  endtask

  function automatic logic [MS_W-1:0] short_delay();
    return ($urandom_range(0, 9) == 0) ? MS_MAX : MS_W'($urandom_range(0, 6));
  endfunction

  // register settings of one random phase
  task automatic configure(input int p);
    logic [MS_W-1:0] t, e, u;
    logic [CFG_DATA_W-1:0] f;
    case (p)
      0: begin f = '1; t = TIMEOUT_RST; e = END_RST; u = UNPLUG_RST; end
      1: begin f = '0; t = '0; e = '0; u = '0; end
      3: begin f = CFG_DATA_W'(pick_addr()); t = MS_MAX; e = 16'd3; u = MS_MAX; end
      default: begin
        f = ($urandom_range(0, 2) == 0) ? CFG_DATA_W'($urandom) : CFG_DATA_W'(pick_addr());
        t = short_delay(); e = short_delay(); u = short_delay();
      end
    endcase
    write_reg(REG_FINISH_ADDRESS, f);
    write_reg(REG_TRANSFER_TO, t);
    write_reg(REG_END_DELAY, e);
    write_reg(REG_UNPLUG_DELAY, u);
    write_reg(p[0] ? REG_IDX_TOP : REG_SPARE, CFG_DATA_W'($urandom));
    tick_span = 2;
    if (t != MS_MAX && t + 2 > tick_span) tick_span = t + 2;
    if (e != MS_MAX && e + 2 > tick_span) tick_span = e + 2;
    if (u != MS_MAX && u + 2 > tick_span) tick_span = u + 2;
    if (tick_span > 120) tick_span = 120;
  endtask

  initial begin : stimulus
    int first, pick;
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    tx_gaps = 1'b1; rush = 1'b0;
    tick_span = 8;
    tracker = new();
    tracker.clear();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, reset register values: unused codes, wrap, session start and end by stop
    for (int c = CMD_TRIGGER + 1; c <= CMD_TOP; c++) send_beat(3'(c), 8'hFF);
    send_beat(CMD_WRITE, 8'hFF);          // high byte loses its top three bits
    send_beat(CMD_WRITE, 8'hFE);
    send_beat(CMD_WRITE, 8'h00);
    send_beat(CMD_WRITE, 8'hFF);          // pointer wraps to zero
    send_beat(CMD_WRITE, 8'hA5);          // stored at address zero
    send_beat(CMD_STOP, 8'h00);
    send_beat(CMD_TRIGGER, 8'h00);
    set_pointer(13'h1FFE);
    send_beat(CMD_STOP, 8'h00);           // below finish address: no end
    repeat (3) send_beat(CMD_READ, 8'h00); // first read starts transmitting
    send_beat(CMD_STOP, 8'h00);
    send_beat(CMD_TICK, 8'h00);
    set_pointer(13'h1FFF);
    send_beat(CMD_STOP, 8'h00);           // at finish address: end wait
    drain();

    // Directed, all-zero registers: stop enters end wait from idle and from unplug delay
    write_reg(REG_FINISH_ADDRESS, '0);
    write_reg(REG_TRANSFER_TO, '0);
    write_reg(REG_END_DELAY, '0);
    write_reg(REG_UNPLUG_DELAY, '0);
    repeat (2) send_beat(CMD_TICK, 8'h00);
    send_beat(CMD_READ, 8'h00);           // idle and inactive: phase stays
    send_beat(CMD_TRIGGER, 8'h00);
    send_beat(CMD_STOP, 8'h00);
    send_beat(CMD_TICK, 8'h00);
    send_beat(CMD_STOP, 8'h00);
    repeat (2) send_beat(CMD_TICK, 8'h00);
    drain();

    // Longest timeout: a 65535 ms timeout does not expire over a run of ticks
    write_reg(REG_FINISH_ADDRESS, '1);
    write_reg(REG_TRANSFER_TO, MS_MAX);
    send_beat(CMD_TRIGGER, 8'h00);
    set_pointer(13'h0000);
    send_beat(CMD_STOP, 8'h00);
    send_beat(CMD_READ, 8'h00);
    rush = 1'b1;
    repeat (SAT_TICKS) send_beat(CMD_TICK, 8'($urandom));
    rush = 1'b0;
    set_pointer(13'h1FFF);
    send_beat(CMD_STOP, 8'h00);
    repeat (2) send_beat(CMD_TICK, 8'h00);
    drain();

    // Random phases, mostly well-formed bus transfers and sessions
    for (int p = 0; p < PHASES; p++) begin
      configure(p);
      if (p == 3) stall_req++;
      first = tracker.items;
      while (tracker.items - first < PHASE_ITEMS) begin
        if ($urandom_range(0, 11) == 0) tx_gaps = !tx_gaps;
        pick = $urandom_range(0, 99);
        if (pick < 25) write_burst();
        else if (pick < 50) read_burst();
        else if (pick < 65) begin
          send_beat(CMD_TRIGGER, 8'($urandom));
          if ($urandom_range(0, 1) == 0) read_burst();
          tick_burst();
        end
        else if (pick < 85) tick_burst();
        else if (pick < 93) send_beat(CMD_STOP, 8'($urandom));
        else send_beat(3'($urandom_range(0, CMD_TOP)), 8'($urandom));
      end
      drain();
    end

    $display("%0d items, %0d results checked, %0d register writes, %0d receiver hold-offs",
             tracker.items, tracker.replies, tracker.cfg_writes, stalls);
    $display("%0d bytes stored, %0d bytes read back, %0d sessions finished",
             tracker.strobes, tracker.reads, tracker.fins);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results still due", tracker.errors, tracker.pending());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### i2c_eeprom_card_emulator_unit.f
design/ceec_pkg.sv
design/ceec_mem.sv
design/ceec_index.sv
design/ceec_ctrl.sv
design/i2c_eeprom_card_emulator_unit.sv
tb/sv/tb_i2c_eeprom_card_emulator_unit.sv
